>>> rtl/core/centered_window_average_top_macros.svh
// Assertion macros for the centered window average block.
// Used by centered_window_average_top; no other dependencies.
`ifndef CENTERED_WINDOW_AVERAGE_TOP_MACROS_SVH
`define CENTERED_WINDOW_AVERAGE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define CWA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CWA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cwa_pkg.sv
// Shared constants for the centered window average block.
// No dependencies.
`timescale 1ns / 1ps

package cwa_pkg;

    localparam int MAX_RADIUS  = 63;
    localparam int SAMPLE_BITS = 32;
    localparam int RADIUS_BITS = 6;
    localparam int RING_AW     = 7;
    localparam int RING_DEPTH  = 1 << RING_AW;
    localparam int SUM_BITS    = 39;
    localparam int AVG_BITS    = 32;
    localparam int OWED_BITS   = RADIUS_BITS;
    localparam int DIVC_BITS   = 6;

    localparam logic [RING_AW-1:0]  COUNT_MAX  = {RING_AW{1'b1}};
    localparam logic [AVG_BITS-1:0] NO_AVERAGE = {AVG_BITS{1'b1}};
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);

endpackage

>>> rtl/core/centered_window_average_top.sv
// Centered moving average over a stream of signed samples, framed by tlast.
// Depends on cwa_pkg and centered_window_average_top_macros.svh.
`timescale 1ns / 1ps
`include "centered_window_average_top_macros.svh"

// One sample is handled at a time. After a transfer on the s_ side, the S_SUM
// state updates the running sum from the ring memory (read issued at the
// transfer and registered) and stores the new sample. A sample that completes
// a full window then runs a radix-2 divider in S_DIV; each result then leaves
// in its own m_ side transfer in S_OUT. A sample without a full window goes
// from S_SUM to S_OUT, or back to S_IDLE if it owes no result. A frame end
// adds up to radius results of -1. s_tready returns after the last result of
// the sample is taken. The radius register (reset 1) may be written only while
// the block is idle.
module centered_window_average_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cwa_pkg::RADIUS_BITS-1:0]  cfg_wr_data,  // radius
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cwa_pkg::SAMPLE_BITS-1:0]  s_tdata,      // [31:0] sample
    input  logic                             s_tlast,      // end_of_sequence
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cwa_pkg::AVG_BITS-1:0]     m_tdata,      // [31:0] average
    output logic                             m_tuser,      // [0] full_window
    output logic                             m_tlast       // last_result
);
    import cwa_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_OUT} state_t;

    state_t                  state_reg;
    logic [RADIUS_BITS-1:0]  radius_reg;
    logic [SUM_BITS-1:0]     running_sum_reg;
    logic [RING_AW-1:0]      samples_seen_reg;
    logic [RING_AW-1:0]      ring_head_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    eos_reg;
    logic [OWED_BITS-1:0]    flush_cnt_reg;
    logic                    last_main_reg;
    logic [SUM_BITS-1:0]     div_quo_reg;
    logic [RING_AW-1:0]      div_rem_reg;
    logic [DIVC_BITS-1:0]    div_cnt_reg;
    logic                    div_neg_reg;
    logic                    m_tvalid_reg;
    logic [AVG_BITS-1:0]     m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    logic [SAMPLE_BITS-1:0]  ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0]  ring_rd_reg;

    logic                    s_xfer;
    logic                    m_xfer;
    logic [RING_AW-1:0]      win_size;
    logic [RING_AW-1:0]      win_twice;
    logic [RING_AW-1:0]      rd_addr;
    logic [SUM_BITS-1:0]     sample_ext;
    logic [SUM_BITS-1:0]     old_ext;
    logic [SUM_BITS-1:0]     sum_fin;
    logic                    main_en;
    logic                    full_en;
    logic [OWED_BITS-1:0]    owed;
    logic [SUM_BITS-1:0]     sum_abs;
    logic [RING_AW:0]        rem_sh;
    logic [RING_AW:0]        rem_diff;
    logic                    rem_ge;
    logic [SUM_BITS-1:0]     quo_step;
    logic [AVG_BITS-1:0]     avg_final;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        win_size   = {radius_reg, 1'b1};
        win_twice  = {radius_reg, 1'b0};
        rd_addr    = ring_head_reg - win_size;
        sample_ext = {{(SUM_BITS-SAMPLE_BITS){s_tdata[SAMPLE_BITS-1]}}, s_tdata};
        old_ext    = {{(SUM_BITS-SAMPLE_BITS){ring_rd_reg[SAMPLE_BITS-1]}}, ring_rd_reg};
        sum_fin    = (samples_seen_reg >= win_size) ? running_sum_reg - old_ext
                                                    : running_sum_reg;
        main_en    = (samples_seen_reg >= RING_AW'(radius_reg));
        full_en    = (samples_seen_reg >= win_twice);
        if (!eos_reg) begin
            owed = '0;
        end else if (main_en) begin
            owed = radius_reg;
        end else begin
            owed = samples_seen_reg[OWED_BITS-1:0] + OWED_BITS'(1);
        end
        sum_abs   = sum_fin[SUM_BITS-1] ? (~sum_fin + SUM_BITS'(1)) : sum_fin;
        rem_sh    = {div_rem_reg, div_quo_reg[SUM_BITS-1]};
        rem_diff  = rem_sh - {1'b0, win_size};
        rem_ge    = (rem_sh >= {1'b0, win_size});
        quo_step  = {div_quo_reg[SUM_BITS-2:0], rem_ge};
        avg_final = div_neg_reg ? (~quo_step[AVG_BITS-1:0] + AVG_BITS'(1))
                                : quo_step[AVG_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_SUM) begin
            ring_mem[ring_head_reg] <= sample_reg;
        end
        if (s_xfer) begin
            ring_rd_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            radius_reg       <= RADIUS_RESET;
            running_sum_reg  <= '0;
            samples_seen_reg <= '0;
            ring_head_reg    <= '0;
            flush_cnt_reg    <= '0;
            eos_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        running_sum_reg <= running_sum_reg + sample_ext;
                        sample_reg      <= s_tdata;
                        eos_reg         <= s_tlast;
                        state_reg       <= S_SUM;
                    end
                end
                S_SUM: begin
                    ring_head_reg <= ring_head_reg + RING_AW'(1);
                    last_main_reg <= eos_reg && (owed == '0);
                    div_quo_reg   <= sum_abs;
                    div_neg_reg   <= sum_fin[SUM_BITS-1];
                    div_rem_reg   <= '0;
                    div_cnt_reg   <= DIVC_BITS'(SUM_BITS - 1);
                    if (eos_reg) begin
                        running_sum_reg  <= '0;
                        samples_seen_reg <= '0;
                    end else begin
                        running_sum_reg  <= sum_fin;
                        samples_seen_reg <= (samples_seen_reg == COUNT_MAX) ? COUNT_MAX
                                          : samples_seen_reg + RING_AW'(1);
                    end
                    priority if (main_en && full_en) begin
                        flush_cnt_reg <= owed;
                        state_reg     <= S_DIV;
                    end else if (main_en) begin
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= NO_AVERAGE;
                        m_tuser_reg   <= 1'b0;
                        m_tlast_reg   <= eos_reg && (owed == '0);
                        flush_cnt_reg <= owed;
                        state_reg     <= S_OUT;
                    end else if (owed != '0) begin
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= NO_AVERAGE;
                        m_tuser_reg   <= 1'b0;
                        m_tlast_reg   <= (owed == OWED_BITS'(1));
                        flush_cnt_reg <= owed - OWED_BITS'(1);
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV: begin
                    div_quo_reg <= quo_step;
                    div_rem_reg <= rem_ge ? rem_diff[RING_AW-1:0] : rem_sh[RING_AW-1:0];
                    div_cnt_reg <= div_cnt_reg - DIVC_BITS'(1);
                    if (div_cnt_reg == '0) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= avg_final;
                        m_tuser_reg  <= 1'b1;
                        m_tlast_reg  <= last_main_reg;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_xfer) begin
                        if (flush_cnt_reg != '0) begin
                            m_tdata_reg   <= NO_AVERAGE;
                            m_tuser_reg   <= 1'b0;
                            m_tlast_reg   <= (flush_cnt_reg == OWED_BITS'(1));
                            flush_cnt_reg <= flush_cnt_reg - OWED_BITS'(1);
                        end else begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `CWA_ASSERT_IMPL(a_no_accept_while_result, aclk, aresetn, s_tready, !m_tvalid, "input open with result pending")
    `CWA_ASSERT_IMPL(a_flush_needs_eos, aclk, aresetn, (flush_cnt_reg != '0) && (state_reg == S_OUT), eos_reg, "flush without frame end")
    `CWA_ASSERT_NEXT(a_div_ends_in_full, aclk, aresetn, (state_reg == S_DIV) && (div_cnt_reg == '0), m_tvalid && m_tuser, "divider end without full result")

endmodule
